### src/nri_pkg.sv
`timescale 1ns / 1ps
// nri_pkg: shared types, constants and saturation helpers for the
// Newton reciprocal square root block. No dependencies.
package nri_pkg;

    localparam int FRAC_BITS = 24;
    localparam int DATA_W    = 32;
    localparam int THR_W     = 31;
    localparam int ITER_W    = 7;

    localparam logic [THR_W-1:0]  THR_RESET = 31'd2;
    localparam logic [ITER_W-1:0] ITER_SAT  = 7'd127;

    typedef enum logic [1:0] {
        ST_CONV  = 2'd0,
        ST_LIMIT = 2'd1,
        ST_OVF   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_SQ_C,
        S_CU,
        S_CU_C,
        S_AX,
        S_AX_C,
        S_UPD,
        S_CHK,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        OP_XX,
        OP_TX,
        OP_AT
    } t_opsel;

    typedef struct packed {
        logic signed [DATA_W-1:0] scale_a;
        logic signed [DATA_W-1:0] start_x;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] root;
        logic [ITER_W-1:0]        iterations;
        t_status                  status;
    } t_out;

    // sequencer controls
    typedef struct packed {
        logic   in_ready;
        logic   out_valid;
        t_opsel opsel;
    } t_ctrl;

    function automatic logic sat_ovf(input logic signed [63:0] v);
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        lo = -64'sd2147483648;
        hi = 64'sd2147483647;
        return (v > hi) || (v < lo);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        lo = -64'sd2147483648;
        hi = 64'sd2147483647;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

### src/newton_rsqrt_iteration.sv
`timescale 1ns / 1ps
// newton_rsqrt_iteration: top level, sequencer and update datapath.
// Uses nri_pkg and nri_fmul.
//
// Usage:
//   Input channel i_in_valid/o_in_ready carries an item {scale_a, start_x},
//   both signed Q8.24. Output channel o_out_valid/i_out_ready returns one
//   item {root, iterations, status} per input item. Config channel
//   i_cfg_valid/o_cfg_ready writes conv_threshold; write it only while idle.
//   One item is processed at a time; o_in_ready is high only when idle.
//   Each Newton step runs three multiplies on the one shared multiplier
//   (issue plus scale/capture each), then update and check.
//   o_out_valid rises after n steps, n = iterations (1..MAX_ITER), and
//   a new item is accepted only once the previous result is taken.
//   If the receiver stalls, the result holds on o_out_data and no new item
//   is taken until it is accepted.
//   Reset returns the sequencer to idle and conv_threshold to 2.
module newton_rsqrt_iteration #(
    parameter int MAX_ITER = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  nri_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output nri_pkg::t_out  o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [nri_pkg::THR_W-1:0] i_cfg_data
);
    import nri_pkg::*;

    localparam int SW = $clog2(MAX_ITER + 1);

    t_state r_state;
    t_state n_state;
    t_ctrl  w_ctrl;

    logic [THR_W-1:0]         r_thr;
    logic signed [DATA_W-1:0] r_a;
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] r_t;
    logic signed [DATA_W-1:0] r_xn;
    logic                     r_ovf;
    logic                     r_conv;
    logic [SW-1:0]            r_steps;
    t_out                     r_out;

    logic signed [DATA_W-1:0] w_op_a;
    logic signed [DATA_W-1:0] w_op_b;
    logic signed [DATA_W-1:0] w_mul_res;
    logic                     w_mul_ovf;

    logic signed [63:0]       w_df_full;
    logic signed [DATA_W-1:0] w_df;
    logic signed [DATA_W-1:0] w_hf;
    logic signed [63:0]       w_xn_full;
    logic signed [DATA_W-1:0] w_xn;
    logic                     w_upd_ovf;
    logic signed [DATA_W:0]   w_d;
    logic [DATA_W:0]          w_mag;
    logic                     w_hit;
    logic [SW-1:0]            w_steps_nx;
    logic                     w_last;
    logic [ITER_W-1:0]        w_iter;

    nri_fmul u_fmul (
        .i_clk  (i_clk),
        .i_op_a (w_op_a),
        .i_op_b (w_op_b),
        .o_res  (w_mul_res),
        .o_ovf  (w_mul_ovf)
    );

    // update datapath
    assign w_df_full  = 64'(r_t) - 64'(r_x);
    assign w_df       = sat32(w_df_full);
    assign w_hf       = w_df >>> 1;
    assign w_xn_full  = 64'(r_x) - 64'(w_hf);
    assign w_xn       = sat32(w_xn_full);
    assign w_upd_ovf  = sat_ovf(w_df_full) | sat_ovf(w_xn_full);

    // check
    assign w_d        = (DATA_W+1)'(r_x) - (DATA_W+1)'(r_xn);
    assign w_mag      = w_d[DATA_W] ? unsigned'(-w_d) : unsigned'(w_d);
    assign w_hit      = w_mag < (DATA_W+1)'(r_thr);
    assign w_steps_nx = r_steps + SW'(1);
    assign w_last     = w_steps_nx == SW'(MAX_ITER);
    assign w_iter     = (32'(w_steps_nx) > 32'(ITER_SAT)) ? ITER_SAT
                                                          : ITER_W'(w_steps_nx);

    always_comb begin
        unique case (w_ctrl.opsel)
            OP_XX: begin
                w_op_a = r_x;
                w_op_b = r_x;
            end
            OP_TX: begin
                w_op_a = r_t;
                w_op_b = r_x;
            end
            OP_AT: begin
                w_op_a = r_a;
                w_op_b = r_t;
            end
            default: begin
                w_op_a = r_x;
                w_op_b = r_x;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_SQ;
            S_SQ:   n_state = S_SQ_C;
            S_SQ_C: n_state = S_CU;
            S_CU:   n_state = S_CU_C;
            S_CU_C: n_state = S_AX;
            S_AX:   n_state = S_AX_C;
            S_AX_C: n_state = S_UPD;
            S_UPD:  n_state = S_CHK;
            S_CHK:  n_state = (w_hit || w_last) ? S_OUT : S_SQ;
            S_OUT:  if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_ctrl = '{in_ready: 1'b0, out_valid: 1'b0, opsel: OP_XX};
        unique case (r_state)
            S_IDLE:  w_ctrl.in_ready  = 1'b1;
            S_CU:    w_ctrl.opsel     = OP_TX;
            S_AX:    w_ctrl.opsel     = OP_AT;
            S_OUT:   w_ctrl.out_valid = 1'b1;
            default: w_ctrl.opsel     = OP_XX;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_thr   <= THR_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_a     <= i_in_data.scale_a;
                    r_x     <= i_in_data.start_x;
                    r_ovf   <= 1'b0;
                    r_steps <= '0;
                end
            end
            S_SQ_C, S_CU_C, S_AX_C: begin
                r_t   <= w_mul_res;
                r_ovf <= r_ovf | w_mul_ovf;
            end
            S_UPD: begin
                r_xn  <= w_xn;
                r_ovf <= r_ovf | w_upd_ovf;
            end
            S_CHK: begin
                r_steps <= w_steps_nx;
                r_conv  <= w_hit;
                if (w_hit || w_last) begin
                    r_out.root       <= r_x;
                    r_out.iterations <= w_iter;
                    r_out.status     <= r_ovf ? ST_OVF : (w_hit ? ST_CONV : ST_LIMIT);
                end else begin
                    r_x <= r_xn;
                end
            end
            default: begin
                r_t <= r_t;
            end
        endcase
    end

    assign o_in_ready  = w_ctrl.in_ready;
    assign o_out_valid = w_ctrl.out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output handshakes open together");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SQ))
        else $error("accepted item did not start iteration");

    a_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (32'(r_steps) <= MAX_ITER))
        else $error("step count past limit");

    a_conv_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !r_ovf && r_conv) |-> (o_out_data.status == ST_CONV))
        else $error("converged item reported wrong status");

endmodule

### src/nri_fmul.sv
`timescale 1ns / 1ps
// nri_fmul: shared signed 32x32 multiplier with registered product,
// followed by the fixed-point floor shift and saturation. Uses nri_pkg.
module nri_fmul (
    input  logic                             i_clk,
    input  logic signed [nri_pkg::DATA_W-1:0] i_op_a,
    input  logic signed [nri_pkg::DATA_W-1:0] i_op_b,
    output logic signed [nri_pkg::DATA_W-1:0] o_res,
    output logic                             o_ovf
);
    import nri_pkg::*;

    logic signed [2*DATA_W-1:0] r_prod;
    logic signed [2*DATA_W-1:0] n_prod;
    logic signed [2*DATA_W-1:0] w_scaled;

    assign n_prod = i_op_a * i_op_b;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    // arithmetic shift rounds toward minus infinity
    assign w_scaled = r_prod >>> FRAC_BITS;
    assign o_res    = sat32(w_scaled);
    assign o_ovf    = sat_ovf(w_scaled);

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for newton_rsqrt_iteration, a directed table
// and then random phases over several thresholds. Needs nri_pkg and the RTL.
module testbench;
    import nri_pkg::*;

    localparam int ITER_LIMIT  = 64;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 1 + 8 * ITER_LIMIT + 8;
    localparam int N_ROWS      = 20;
    localparam int N_PHASES    = 9;
    localparam int PHASE_ITEMS = 50;
    localparam logic [THR_W-1:0] THR_MAX = '1;

    typedef struct packed {
        logic              set_thr;
        logic [THR_W-1:0]  thr;
        logic [31:0]       scale_a;
        logic [31:0]       start_x;
        logic              typed;
        logic [31:0]       root;
        logic [ITER_W-1:0] iter;
        t_status           st;
    } t_row;

    logic             i_clk       = 1'b0;
    logic             i_out_ready = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in              i_in_data;
    logic             o_out_valid;
    t_out             o_out_data;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [THR_W-1:0] i_cfg_data;

    t_out             root_due [$];
    t_out             want;
    t_row             plan [0:N_ROWS-1];
    logic [THR_W-1:0] thr_now;
    bit               idle_on;
    int               rx_wait;
    int               rx_draw;
    int               quiet_cycles = 0;
    int               errors = 0;
    int               n_sent = 0;
    int               n_done = 0;
    int               n_conv = 0;
    int               n_limit = 0;
    int               n_ovf = 0;
    int               n_thr = 0;

    newton_rsqrt_iteration uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // x <- x - (a*x^3 - x)/2 until step < thr or ITER_LIMIT steps; reports x before the last step
    function automatic t_out rsqrt_newton(input t_in item, input logic [THR_W-1:0] thr);
        logic signed [63:0] a, x, xn, prev, raw, x2, x3, ax3, df, step_mag;
        logic ovf, hit;
        int n;
        t_out res;
        a = $signed(item.scale_a);
        x = $signed(item.start_x);
        ovf = 1'b0;
        hit = 1'b0;
        n = 0;
        prev = x;
        while (n < ITER_LIMIT && !hit) begin
            raw = (x * x) >>> FRAC_BITS;
            x2 = clip32(raw);
            ovf |= (raw != x2);
            raw = (x2 * x) >>> FRAC_BITS;
            x3 = clip32(raw);
            ovf |= (raw != x3);
            raw = (a * x3) >>> FRAC_BITS;
            ax3 = clip32(raw);
            ovf |= (raw != ax3);
            raw = ax3 - x;
            df = clip32(raw);
            ovf |= (raw != df);
            raw = x - (df >>> 1);
            xn = clip32(raw);
            ovf |= (raw != xn);
            step_mag = (x > xn) ? x - xn : xn - x;
            n++;
            prev = x;
            if (step_mag < $signed({33'd0, thr})) hit = 1'b1;
            else x = xn;
        end
        res.root = prev[31:0];
        res.iterations = (n > 127) ? ITER_SAT : 7'(n);
        res.status = ovf ? ST_OVF : (hit ? ST_CONV : ST_LIMIT);
        return res;
    endfunction

    task automatic feed(input t_in item, input bit typed, input t_out row_want);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        root_due.push_back(typed ? row_want : rsqrt_newton(item, thr_now));
        n_sent++;
    endtask

    // drains all pending results before touching the register
    task automatic set_threshold(input logic [THR_W-1:0] v);
        i_in_valid <= 1'b0;
        while (root_due.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        thr_now = v;
        n_thr++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_wait     <= 0;
        end else if (o_out_valid && i_out_ready) begin
            if (root_due.size() == 0) begin
                errors++;
                $display("%0t unexpected item: root=%h iter=%0d status=%0d", $time,
                         o_out_data.root, o_out_data.iterations, o_out_data.status);
            end else begin
                want = root_due.pop_front();
                if (o_out_data.root !== want.root || o_out_data.iterations !== want.iterations
                        || o_out_data.status !== want.status) begin
                    errors++;
                    $display("%0t mismatch: exp root=%h it=%0d st=%0d, got root=%h it=%0d st=%0d",
                             $time, want.root, want.iterations, want.status,
                             o_out_data.root, o_out_data.iterations, o_out_data.status);
                end
            end
            n_done++;
            case (o_out_data.status)
                ST_CONV:  n_conv++;
                ST_LIMIT: n_limit++;
                default:  n_ovf++;
            endcase
            rx_draw = idle_on ? $urandom_range(0, 3) : 0;
            i_out_ready <= (rx_draw == 0);
            rx_wait     <= rx_draw;
        end else if (!i_out_ready) begin
            if (rx_wait <= 1) i_out_ready <= 1'b1;
            rx_wait <= rx_wait - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("%0t watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin
        t_row        r;
        t_out        row_want;
        t_in         item;
        logic [31:0] a_bits;
        real         xr;
        int          e;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        thr_now = THR_RESET;
        idle_on = 1'b1;

        // set_thr, thr, a, x0, typed, root, iterations, status
        plan[0]  = '{1'b0, 31'd0, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 7'd1, ST_CONV};
        plan[1]  = '{1'b0, 31'd0, 32'h0100_0000, 32'h0100_0000, 1'b1, 32'h0100_0000, 7'd1, ST_CONV};
        plan[2]  = '{1'b0, 31'd0, 32'h0400_0000, 32'h0080_0000, 1'b1, 32'h0080_0000, 7'd1, ST_CONV};
        plan[3]  = '{1'b0, 31'd0, 32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 7'd1, ST_CONV};
        plan[4]  = '{1'b0, 31'd0, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 7'd1, ST_CONV};
        plan[5]  = '{1'b0, 31'd0, 32'h0100_0000, 32'hFF00_0000, 1'b1, 32'hFF00_0000, 7'd1, ST_CONV};
        plan[6]  = '{1'b0, 31'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0, 7'd0, ST_CONV};
        plan[7]  = '{1'b0, 31'd0, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0, 7'd0, ST_CONV};
        plan[8]  = '{1'b0, 31'd0, 32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0, 7'd0, ST_CONV};
        plan[9]  = '{1'b0, 31'd0, 32'hFF00_0000, 32'h0100_0000, 1'b0, 32'h0, 7'd0, ST_CONV};
        plan[10] = '{1'b0, 31'd0, 32'h0200_0000, 32'h00B3_3333, 1'b0, 32'h0, 7'd0, ST_CONV};
        plan[11] = '{1'b0, 31'd0, 32'h0040_0000, 32'h01E6_6666, 1'b0, 32'h0, 7'd0, ST_CONV};
        plan[12] = '{1'b0, 31'd0, 32'h0100_0000, 32'h0000_0001, 1'b0, 32'h0, 7'd0, ST_CONV};
        // zero threshold: the bound is never met
        plan[13] = '{1'b1, 31'd0, 32'h0100_0000, 32'h0100_0000, 1'b1, 32'h0100_0000, 7'd64,
                     ST_LIMIT};
        plan[14] = '{1'b0, 31'd0, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 7'd64,
                     ST_LIMIT};
        plan[15] = '{1'b1, 31'd1, 32'h0100_0000, 32'h00C0_0000, 1'b0, 32'h0, 7'd0, ST_CONV};
        plan[16] = '{1'b1, THR_MAX, 32'h0100_0000, 32'h0200_0000, 1'b1, 32'h0200_0000, 7'd1,
                     ST_CONV};
        // saturates on x^2 yet meets the bound in one step
        plan[17] = '{1'b0, 31'd0, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 7'd1,
                     ST_OVF};
        plan[18] = '{1'b0, 31'd0, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0, 7'd0, ST_CONV};
        plan[19] = '{1'b1, THR_RESET, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 32'h0, 7'd0, ST_CONV};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_ROWS; k++) begin
            r = plan[k];
            if (r.set_thr) set_threshold(r.thr);
            item.scale_a        = r.scale_a;
            item.start_x        = r.start_x;
            row_want.root       = r.root;
            row_want.iterations = r.iter;
            row_want.status     = r.st;
            feed(item, r.typed, row_want);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0:       set_threshold(THR_RESET);
                1:       set_threshold(31'($urandom_range(1, 4095)));
                2:       set_threshold('0);
                3:       set_threshold(31'd16);
                4:       set_threshold(THR_MAX);
                5:       set_threshold(31'($urandom));
                6:       set_threshold(31'($urandom_range(1, 1 << 20)));
                7:       set_threshold(31'd1);
                default: set_threshold(31'($urandom_range(1, 255)));
            endcase
            idle_on = (ph % 3 != 2);
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                if ($urandom_range(0, 3) != 0) begin
                    // positive a, guess within the basin of 1/sqrt(a)
                    e = $urandom_range(16, 30);
                    a_bits = (32'd1 << e) | ($urandom & ((32'd1 << e) - 1));
                    xr = ($urandom_range(300, 1600) / 1000.0) / $sqrt(a_bits / 16777216.0);
                    item.scale_a = a_bits;
                    item.start_x = $rtoi(xr * 16777216.0);
                end else begin
                    item.scale_a = $urandom;
                    item.start_x = $urandom;
                end
                feed(item, 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        while (root_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("ran %0d items under %0d threshold writes, directed extremes then random phases",
                 n_sent, n_thr);
        $display("got %0d results: %0d converged, %0d hit the limit, %0d saturated, %0d errors",
                 n_done, n_conv, n_limit, n_ovf, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
